>>> rtl/pvpd_pkg.sv
// Package for the prefix varint pair decoder: payload structs, header codes
// and the result queue size. No dependencies.
package pvpd_pkg;

    // Input transaction: one byte of the encoded stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } pvpd_in_t;

    // Result transaction
    typedef struct packed {
        logic [63:0] decoded_value;
        logic        last_in_run;
        logic        truncated;
    } pvpd_out_t;

    // Decode of one byte against the held state
    typedef struct packed {
        logic [1:0]  res_count;
        pvpd_out_t   res0;
        pvpd_out_t   res1;
        logic [63:0] partial_next;
        logic [3:0]  left_next;
    } pvpd_dec_t;

    // Header masks and match codes
    localparam logic [7:0] HDR_MASK_1 = 8'h80;
    localparam logic [7:0] HDR_MASK_2 = 8'hC0;
    localparam logic [7:0] HDR_MASK_3 = 8'hE0;
    localparam logic [7:0] HDR_MASK_4 = 8'hF0;
    localparam logic [7:0] HDR_MASK_5 = 8'hF8;
    localparam logic [7:0] HDR_MASK_6 = 8'hFC;
    localparam logic [7:0] HDR_MASK_7 = 8'hFE;
    localparam logic [7:0] HDR_PAIR   = 8'h80;
    localparam logic [7:0] HDR_CONT1  = 8'hC0;
    localparam logic [7:0] HDR_CONT2  = 8'hE0;
    localparam logic [7:0] HDR_CONT3  = 8'hF0;
    localparam logic [7:0] HDR_CONT4  = 8'hF8;
    localparam logic [7:0] HDR_CONT5  = 8'hFC;
    localparam logic [7:0] HDR_CONT6  = 8'hFE;

    // Continuation byte counts per header form
    localparam logic [3:0] LEFT_CONT1 = 4'd1;
    localparam logic [3:0] LEFT_CONT2 = 4'd2;
    localparam logic [3:0] LEFT_CONT3 = 4'd3;
    localparam logic [3:0] LEFT_CONT4 = 4'd4;
    localparam logic [3:0] LEFT_CONT5 = 4'd5;
    localparam logic [3:0] LEFT_CONT6 = 4'd6;
    localparam logic [3:0] LEFT_CONT8 = 4'd8;

    // Result queue depth: room for two results of one byte plus drain slack
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage

>>> rtl/pvpd_decode.sv
// Combinational decode of one stream byte against the partial value state.
// Depends on pvpd_pkg.
module pvpd_decode
    import pvpd_pkg::*;
(
    input  pvpd_in_t    in_data,
    input  logic [63:0] partial_value,
    input  logic [3:0]  bytes_left,
    output pvpd_dec_t   dec
);

    logic [7:0]  b;
    logic [63:0] shifted;
    logic [3:0]  left_dec;

    assign b        = in_data.data_byte;
    assign shifted  = {partial_value[55:0], b};
    assign left_dec = bytes_left - 4'd1;

    // Header / continuation decode, then truncation override
    always_comb begin
        dec = '0;
        dec.partial_next = partial_value;
        dec.left_next    = bytes_left;

        if (bytes_left != 4'd0) begin
            dec.partial_next = shifted;
            dec.left_next    = left_dec;
            if (left_dec == 4'd0) begin
                dec.res_count          = 2'd1;
                dec.res0.decoded_value = shifted;
                dec.res0.last_in_run   = 1'b1;
                dec.partial_next       = '0;
            end
        end else if ((b & HDR_MASK_1) == 8'h00) begin
            dec.res_count          = 2'd1;
            dec.res0.decoded_value = {56'd0, b};
            dec.res0.last_in_run   = 1'b1;
        end else if ((b & HDR_MASK_2) == HDR_PAIR) begin
            dec.res_count          = 2'd2;
            dec.res0.decoded_value = {61'd0, b[5:3]};
            dec.res1.decoded_value = {61'd0, b[2:0]};
            dec.res1.last_in_run   = 1'b1;
        end else if ((b & HDR_MASK_3) == HDR_CONT1) begin
            dec.partial_next = {59'd0, b[4:0]};
            dec.left_next    = LEFT_CONT1;
        end else if ((b & HDR_MASK_4) == HDR_CONT2) begin
            dec.partial_next = {60'd0, b[3:0]};
            dec.left_next    = LEFT_CONT2;
        end else if ((b & HDR_MASK_5) == HDR_CONT3) begin
            dec.partial_next = {61'd0, b[2:0]};
            dec.left_next    = LEFT_CONT3;
        end else if ((b & HDR_MASK_6) == HDR_CONT4) begin
            dec.partial_next = {62'd0, b[1:0]};
            dec.left_next    = LEFT_CONT4;
        end else if ((b & HDR_MASK_7) == HDR_CONT5) begin
            dec.partial_next = {63'd0, b[0]};
            dec.left_next    = LEFT_CONT5;
        end else if (b == HDR_CONT6) begin
            dec.partial_next = '0;
            dec.left_next    = LEFT_CONT6;
        end else begin
            dec.partial_next = '0;
            dec.left_next    = LEFT_CONT8;
        end

        // Stream ends with bytes still due: no other result in these cases
        if (in_data.stream_end && (dec.left_next != 4'd0)) begin
            dec.partial_next = '0;
            dec.left_next    = '0;
            dec.res_count    = 2'd1;
            dec.res0         = '0;
            dec.res0.last_in_run = 1'b1;
            dec.res0.truncated   = 1'b1;
        end
    end

endmodule

>>> rtl/pvpd_out_queue.sv
// Small result queue: takes up to two results a cycle, hands out one
// while m_ready is high. Depends on pvpd_pkg.
module pvpd_out_queue
    import pvpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic [1:0] push_count,
    input  pvpd_out_t push0,
    input  pvpd_out_t push1,
    output logic      room2,
    output logic      m_valid,
    input  logic      m_ready,
    output pvpd_out_t m_data
);

    pvpd_out_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;
    logic              pop;

    assign m_valid   = (count_reg != '0);
    assign m_data    = q_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    assign room2     = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            q_reg[wr_ptr_p1] <= push1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> (count_reg <= QCNT_W'(QDEPTH - 2)))
        else $error("push without room for a full byte's results");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result lost while stalled");
`endif

endmodule

>>> rtl/prefix_varint_pair_decoder.sv
// Top level of the prefix varint pair decoder: input register, byte decode,
// state registers and result queue. Depends on pvpd_pkg, pvpd_decode, pvpd_out_queue.
//
//  Channel  Ports                         Transaction
//  input    s_valid s_ready s_data        one stream byte plus end flag
//  result   m_valid m_ready m_data        one decoded value or truncation mark
//
// One byte is taken per cycle while the queue has room for two results. Each byte
// waits in the input register; its results then enter the queue and are offered.
// A pair header yields two results, so for such bytes the output port sets the rate.
// aresetn (synchronous) clears the stream state and empties the queue.
// A stalled output backs up into the 4-entry queue and then the input register.
module prefix_varint_pair_decoder
    import pvpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pvpd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pvpd_out_t m_data
);

    logic        in_valid_reg, in_valid_next;
    pvpd_in_t    in_data_reg;
    logic [63:0] partial_reg, partial_next;
    logic [3:0]  left_reg, left_next;
    pvpd_dec_t   dec;
    logic        room2;
    logic        advance;
    logic [1:0]  push_count;

    // Handshake and pipeline advance
    assign advance    = in_valid_reg && room2;
    assign s_ready    = !in_valid_reg || advance;
    assign push_count = advance ? dec.res_count : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        partial_next = advance ? dec.partial_next : partial_reg;
        left_next    = advance ? dec.left_next : left_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            partial_reg  <= '0;
            left_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            partial_reg  <= partial_next;
            left_reg     <= left_next;
        end
    end

    // Input payload register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    pvpd_decode u_decode (
        .in_data       (in_data_reg),
        .partial_value (partial_reg),
        .bytes_left    (left_reg),
        .dec           (dec)
    );

    pvpd_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (dec.res0),
        .push1      (dec.res1),
        .room2      (room2),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= LEFT_CONT8)
        else $error("continuation count out of range");

    a_trunc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.truncated) |->
            (m_data.decoded_value == 64'd0 && m_data.last_in_run))
        else $error("truncation result carries a value");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count == 2'd2) |-> (!dec.res0.last_in_run && dec.res1.last_in_run))
        else $error("pair results out of order");
`endif

endmodule
